[design/olps_pkg.sv]
// Package for the octant line pixel stepper.
// Holds widths, command and register codes, the direction case type and its step table.
// Used by every design file; depends on nothing.
package olps_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAME_BITS = 13;
	localparam int INDEX_BITS = 24;
	localparam int CFG_INDEX_BITS = 1;

	localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RST = 13'd640;
	localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

	typedef enum logic [3:0] {
		DIR_OCT0,
		DIR_OCT1,
		DIR_OCT2,
		DIR_OCT3,
		DIR_OCT4,
		DIR_OCT5,
		DIR_OCT6,
		DIR_OCT7,
		DIR_UP,
		DIR_DOWN,
		DIR_LEFT,
		DIR_RIGHT
	} dir_case_t;

	typedef struct packed {
		logic signed [1:0] sx;
		logic signed [1:0] sy;
		logic x_major;
	} dir_step_t;

	function automatic dir_step_t dir_step(dir_case_t c);
		dir_step_t d;
		case (c)
			DIR_OCT0: d = '{sx: 2'sd1, sy: 2'sd1, x_major: 1'b1};
			DIR_OCT1: d = '{sx: 2'sd1, sy: 2'sd1, x_major: 1'b0};
			DIR_OCT2: d = '{sx: -2'sd1, sy: 2'sd1, x_major: 1'b0};
			DIR_OCT3: d = '{sx: -2'sd1, sy: 2'sd1, x_major: 1'b1};
			DIR_OCT4: d = '{sx: -2'sd1, sy: -2'sd1, x_major: 1'b1};
			DIR_OCT5: d = '{sx: -2'sd1, sy: -2'sd1, x_major: 1'b0};
			DIR_OCT6: d = '{sx: 2'sd1, sy: -2'sd1, x_major: 1'b0};
			DIR_OCT7: d = '{sx: 2'sd1, sy: -2'sd1, x_major: 1'b1};
			DIR_UP: d = '{sx: 2'sd0, sy: 2'sd1, x_major: 1'b0};
			DIR_DOWN: d = '{sx: 2'sd0, sy: -2'sd1, x_major: 1'b0};
			DIR_LEFT: d = '{sx: -2'sd1, sy: 2'sd0, x_major: 1'b1};
			DIR_RIGHT: d = '{sx: 2'sd1, sy: 2'sd0, x_major: 1'b1};
			default: d = '{sx: 2'sd0, sy: 2'sd0, x_major: 1'b1};
		endcase
		return d;
	endfunction

endpackage

[design/olps_if.sv]
// Valid/ready channel interfaces for line commands and emitted pixels.
// Depends on olps_pkg for the default coordinate width.
interface olps_cmd_if #(parameter int COORD_BITS = olps_pkg::COORD_BITS_DEF);
	logic valid;
	logic ready;
	logic command;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;

	modport source(output valid, command, start_x, start_y, end_x, end_y, input ready);
	modport sink(input valid, command, start_x, start_y, end_x, end_y, output ready);
endinterface

interface olps_pix_if #(parameter int COORD_BITS = olps_pkg::COORD_BITS_DEF);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic on_screen;
	logic [olps_pkg::INDEX_BITS-1:0] pixel_index;
	logic last_pixel;

	modport source(output valid, pixel_x, pixel_y, on_screen, pixel_index, last_pixel,
		input ready);
	modport sink(input valid, pixel_x, pixel_y, on_screen, pixel_index, last_pixel,
		output ready);
endinterface

[design/olps_stepper.sv]
// Line state and midpoint decision update; emits one pixel coordinate per step transfer while a line is active.
// Depends on olps_pkg and olps_cmd_if.
module olps_stepper #(
	parameter int COORD_BITS = olps_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	olps_cmd_if.sink                     cmd,
	output logic                         s1_valid,
	input  logic                         s1_ready,
	output logic signed [COORD_BITS-1:0] s1_x,
	output logic signed [COORD_BITS-1:0] s1_y,
	output logic                         s1_last
);
	import olps_pkg::*;

	localparam int AW = COORD_BITS + 1;
	localparam int DW = COORD_BITS + 4;

	logic                         line_active_q;
	logic                         emitted_first_q;
	logic signed [COORD_BITS-1:0] cur_x_q;
	logic signed [COORD_BITS-1:0] cur_y_q;
	logic signed [DW-1:0]         dec_q;
	logic [AW-1:0]                abs_dx_q;
	logic [AW-1:0]                abs_dy_q;
	logic [AW-1:0]                steps_q;
	dir_case_t                    dir_q;

	logic                         accept;
	logic                         do_start;
	logic                         do_step;
	logic signed [AW-1:0]         dx;
	logic signed [AW-1:0]         dy;
	logic [AW-1:0]                ax;
	logic [AW-1:0]                ay;
	logic                         x_ge;
	logic [AW-1:0]                big;
	logic [AW-1:0]                small_d;
	logic signed [DW-1:0]         dec_init;
	dir_case_t                    dir_init;

	dir_step_t                    ds;
	logic [AW-1:0]                step_big;
	logic [AW-1:0]                step_small;
	logic                         diag;
	logic signed [DW-1:0]         dec_next;
	logic signed [COORD_BITS-1:0] nx;
	logic signed [COORD_BITS-1:0] ny;
	logic [AW-1:0]                steps_dec;
	logic                         last;

	assign cmd.ready = !s1_valid || s1_ready;
	assign accept = cmd.valid && cmd.ready;
	assign do_start = accept && (cmd.command == CMD_START);
	assign do_step = accept && (cmd.command == CMD_STEP) && line_active_q;

	always_comb begin
		dx = AW'(cmd.end_x) - AW'(cmd.start_x);
		dy = AW'(cmd.end_y) - AW'(cmd.start_y);
		ax = dx[AW-1] ? AW'(-dx) : AW'(dx);
		ay = dy[AW-1] ? AW'(-dy) : AW'(dy);
		x_ge = ax >= ay;
		big = x_ge ? ax : ay;
		small_d = x_ge ? ay : ax;
		dec_init = $signed(DW'({small_d, 1'b0})) - $signed(DW'(big));
		if (dx == '0) begin
			dir_init = (!dy[AW-1] && (dy != '0)) ? DIR_UP : DIR_DOWN;
		end else if (dy == '0) begin
			dir_init = dx[AW-1] ? DIR_LEFT : DIR_RIGHT;
		end else if (!dx[AW-1] && !dy[AW-1]) begin
			dir_init = x_ge ? DIR_OCT0 : DIR_OCT1;
		end else if (dx[AW-1] && !dy[AW-1]) begin
			dir_init = x_ge ? DIR_OCT3 : DIR_OCT2;
		end else if (dx[AW-1]) begin
			dir_init = x_ge ? DIR_OCT4 : DIR_OCT5;
		end else begin
			dir_init = x_ge ? DIR_OCT7 : DIR_OCT6;
		end
	end

	always_comb begin
		ds = dir_step(dir_q);
		step_big = ds.x_major ? abs_dx_q : abs_dy_q;
		step_small = ds.x_major ? abs_dy_q : abs_dx_q;
		diag = !dec_q[DW-1] && (dec_q != '0);
		if (diag) begin
			dec_next = dec_q + $signed(DW'({step_small, 1'b0})) - $signed(DW'({step_big, 1'b0}));
		end else begin
			dec_next = dec_q + $signed(DW'({step_small, 1'b0}));
		end
		nx = (ds.x_major || diag) ? cur_x_q + COORD_BITS'(ds.sx) : cur_x_q;
		ny = (!ds.x_major || diag) ? cur_y_q + COORD_BITS'(ds.sy) : cur_y_q;
		steps_dec = steps_q - AW'(1);
		last = steps_dec == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_active_q <= 1'b0;
			emitted_first_q <= 1'b0;
			s1_valid <= 1'b0;
		end else begin
			if (cmd.ready) begin
				s1_valid <= do_step;
			end
			if (do_start) begin
				emitted_first_q <= 1'b0;
				line_active_q <= big != '0;
			end else if (do_step) begin
				emitted_first_q <= 1'b1;
				if (last) begin
					line_active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_start) begin
			dir_q <= dir_init;
			abs_dx_q <= ax;
			abs_dy_q <= ay;
			cur_x_q <= cmd.start_x;
			cur_y_q <= cmd.start_y;
			dec_q <= dec_init;
			steps_q <= big;
		end else if (do_step) begin
			steps_q <= steps_dec;
			if (emitted_first_q) begin
				cur_x_q <= nx;
				cur_y_q <= ny;
				dec_q <= dec_next;
			end
		end
		if (do_step) begin
			s1_x <= emitted_first_q ? nx : cur_x_q;
			s1_y <= emitted_first_q ? ny : cur_y_q;
			s1_last <= last;
		end
	end

	a_active_has_steps: assert property (@(posedge clk) disable iff (!arst_n)
		line_active_q |-> steps_q != '0)
		else $error("active line with no steps left");

	a_start_resets_first: assert property (@(posedge clk) disable iff (!arst_n)
		do_start |=> !emitted_first_q && (line_active_q == (steps_q != '0)))
		else $error("start did not load line state");

	a_idle_step_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd.command == CMD_STEP) && !line_active_q |=> !s1_valid)
		else $error("pixel emitted with no line active");

endmodule

[design/olps_pixel_map.sv]
// Frame size registers, clipping and bottom-left-origin framebuffer index pipeline.
// Depends on olps_pkg and olps_pix_if.
module olps_pixel_map #(
	parameter int COORD_BITS = olps_pkg::COORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [olps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [olps_pkg::FRAME_BITS-1:0]       cfg_wdata,
	input  logic                                  s1_valid,
	output logic                                  s1_ready,
	input  logic signed [COORD_BITS-1:0]          s1_x,
	input  logic signed [COORD_BITS-1:0]          s1_y,
	input  logic                                  s1_last,
	olps_pix_if.source                            pix
);
	import olps_pkg::*;

	localparam int CW = (COORD_BITS > FRAME_BITS) ? COORD_BITS : FRAME_BITS;
	localparam int PW = 2 * FRAME_BITS;

	logic [FRAME_BITS-1:0]        frame_w_q;
	logic [FRAME_BITS-1:0]        frame_h_q;

	logic                         on_c;
	logic                         v_s2;
	logic                         on_s2;
	logic [FRAME_BITS-1:0]        row_s2;
	logic [FRAME_BITS-1:0]        xcut_s2;
	logic signed [COORD_BITS-1:0] x_s2;
	logic signed [COORD_BITS-1:0] y_s2;
	logic                         last_s2;
	logic                         v_s3;
	logic                         on_s3;
	logic [PW-1:0]                prod_s3;
	logic [FRAME_BITS-1:0]        xcut_s3;
	logic signed [COORD_BITS-1:0] x_s3;
	logic signed [COORD_BITS-1:0] y_s3;
	logic                         last_s3;
	logic                         rdy_out;
	logic                         rdy_s3;
	logic                         rdy_s2;

	assign rdy_out = !pix.valid || pix.ready;
	assign rdy_s3 = !v_s3 || rdy_out;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign s1_ready = rdy_s2;

	assign on_c = !s1_x[COORD_BITS-1] && !s1_y[COORD_BITS-1]
		&& (CW'($unsigned(s1_x)) < CW'(frame_w_q))
		&& (CW'($unsigned(s1_y)) < CW'(frame_h_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q <= FRAME_WIDTH_RST;
			frame_h_q <= FRAME_HEIGHT_RST;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			pix.valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH: frame_w_q <= cfg_wdata;
					REG_FRAME_HEIGHT: frame_h_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (rdy_s2) begin
				v_s2 <= s1_valid;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_out) begin
				pix.valid <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && s1_valid) begin
			on_s2 <= on_c;
			row_s2 <= on_c ? frame_h_q - FRAME_BITS'(1) - FRAME_BITS'($unsigned(s1_y)) : '0;
			xcut_s2 <= on_c ? FRAME_BITS'($unsigned(s1_x)) : '0;
			x_s2 <= s1_x;
			y_s2 <= s1_y;
			last_s2 <= s1_last;
		end
		if (rdy_s3 && v_s2) begin
			on_s3 <= on_s2;
			prod_s3 <= PW'(row_s2) * PW'(frame_w_q);
			xcut_s3 <= xcut_s2;
			x_s3 <= x_s2;
			y_s3 <= y_s2;
			last_s3 <= last_s2;
		end
		if (rdy_out && v_s3) begin
			pix.pixel_x <= x_s3;
			pix.pixel_y <= y_s3;
			pix.on_screen <= on_s3;
			pix.pixel_index <= INDEX_BITS'(prod_s3 + PW'(xcut_s3));
			pix.last_pixel <= last_s3;
		end
	end

	a_off_screen_zero_row: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !on_s2 |-> (row_s2 == '0) && (xcut_s2 == '0))
		else $error("off-screen pixel carries a nonzero row or column");

	a_off_screen_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && !pix.on_screen |-> pix.pixel_index == '0)
		else $error("off-screen pixel has a nonzero index");

	a_s1_transfer_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && s1_ready |=> v_s2)
		else $error("pixel lost between stepper and index stage");

endmodule

[design/octant_line_pixel_stepper.sv]
// Top level of the octant line pixel stepper: stepper followed by the index pipeline.
// An active-line step passes registers s1, s2, s3 and pix; a start yields no pixel.
// Throughput: one command per cycle while pix back-pressure does not stall the pipeline.
// Reset clears the line state and all pipeline valids and sets the frame to 640 by 480.
// Depends on olps_pkg, olps_if, olps_stepper and olps_pixel_map.
module octant_line_pixel_stepper #(
	parameter int COORD_BITS = olps_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [olps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [olps_pkg::FRAME_BITS-1:0]     cfg_wdata,
	olps_cmd_if.sink                            cmd,
	olps_pix_if.source                          pix
);
	logic                         s1_valid;
	logic                         s1_ready;
	logic signed [COORD_BITS-1:0] s1_x;
	logic signed [COORD_BITS-1:0] s1_y;
	logic                         s1_last;

	olps_stepper #(
		.COORD_BITS(COORD_BITS)
	) u_stepper (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.s1_valid (s1_valid),
		.s1_ready (s1_ready),
		.s1_x     (s1_x),
		.s1_y     (s1_y),
		.s1_last  (s1_last)
	);

	olps_pixel_map #(
		.COORD_BITS(COORD_BITS)
	) u_pixel_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s1_valid  (s1_valid),
		.s1_ready  (s1_ready),
		.s1_x      (s1_x),
		.s1_y      (s1_y),
		.s1_last   (s1_last),
		.pix       (pix)
	);

endmodule

[tb/sv/octant_line_pixel_stepper_tb.sv]
// Testbench for the octant line pixel stepper: directed lines, then random line sequences
// over several frame sizes, each pixel checked against an in-bench Bresenham predictor.
// Depends on olps_pkg, the olps_cmd_if and olps_pix_if interfaces and the top level.
module octant_line_pixel_stepper_tb;
	import olps_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int ITEMS_PER_PHASE = 122;

	typedef struct {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic on;
		logic [INDEX_BITS-1:0] idx;
		logic last;
	} pixel_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [FRAME_BITS-1:0] cfg_wdata;

	olps_cmd_if #(.COORD_BITS(CB)) cmd_ch();
	olps_pix_if #(.COORD_BITS(CB)) pix_ch();

	octant_line_pixel_stepper #(.COORD_BITS(CB)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cmd(cmd_ch),
		.pix(pix_ch)
	);

	pixel_t pending_pixels[$];
	int errors = 0;
	int sent_cmds = 0;
	int checked_pixels = 0;
	int idle_cycles = 0;
	bit no_idle = 0;

	logic [FRAME_BITS-1:0] fb_width = FRAME_WIDTH_RST;
	logic [FRAME_BITS-1:0] fb_height = FRAME_HEIGHT_RST;
	bit ln_active = 0;
	bit ln_started = 0;
	logic signed [CB-1:0] pos_x = '0;
	logic signed [CB-1:0] pos_y = '0;
	int err_term = 0;
	int span_x = 0;
	int span_y = 0;
	int left_count = 0;
	int step_x = 0;
	int step_y = 0;
	bit x_lead = 1;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_error(input string msg);
		$display("tb: mismatch: %s", msg);
		errors++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_error($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic predict_command(input logic c, input logic signed [CB-1:0] sx,
		input logic signed [CB-1:0] sy, input logic signed [CB-1:0] ex,
		input logic signed [CB-1:0] ey, output bit made);
		int dx;
		int dy;
		int major;
		int minor;
		bit diag;
		longint row;
		pixel_t p;
		made = 0;
		if (c == CMD_START) begin
			dx = int'(ex) - int'(sx);
			dy = int'(ey) - int'(sy);
			span_x = dx < 0 ? -dx : dx;
			span_y = dy < 0 ? -dy : dy;
			step_x = dx > 0 ? 1 : (dx < 0 ? -1 : 0);
			step_y = dy > 0 ? 1 : (dy < 0 ? -1 : 0);
			x_lead = (dx != 0) && (span_x >= span_y);
			major = span_x >= span_y ? span_x : span_y;
			minor = span_x >= span_y ? span_y : span_x;
			err_term = 2 * minor - major;
			left_count = major;
			pos_x = sx;
			pos_y = sy;
			ln_started = 0;
			ln_active = major != 0;
		end else if (ln_active) begin
			if (!ln_started) begin
				ln_started = 1;
			end else begin
				major = x_lead ? span_x : span_y;
				minor = x_lead ? span_y : span_x;
				diag = err_term > 0;
				err_term += diag ? 2 * minor - 2 * major : 2 * minor;
				if (x_lead) begin
					pos_x = CB'(pos_x + step_x);
					if (diag)
						pos_y = CB'(pos_y + step_y);
				end else begin
					pos_y = CB'(pos_y + step_y);
					if (diag)
						pos_x = CB'(pos_x + step_x);
				end
			end
			left_count--;
			p.x = pos_x;
			p.y = pos_y;
			p.last = left_count <= 0;
			p.on = pos_x >= 0 && pos_y >= 0 && int'(pos_x) < int'(fb_width) &&
				int'(pos_y) < int'(fb_height);
			row = longint'(fb_height) - 1 - longint'(pos_y);
			p.idx = p.on ? INDEX_BITS'(row * longint'(fb_width) + longint'(pos_x)) : '0;
			pending_pixels.push_back(p);
			made = 1;
			if (p.last)
				ln_active = 0;
		end
	endtask

	task automatic send_command(input logic c, input int sx, input int sy, input int ex,
		input int ey, output bit made);
		while (!no_idle && $urandom_range(0, 99) < 17) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= c;
		cmd_ch.start_x <= CB'(sx);
		cmd_ch.start_y <= CB'(sy);
		cmd_ch.end_x <= CB'(ex);
		cmd_ch.end_y <= CB'(ey);
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		sent_cmds++;
		predict_command(c, CB'(sx), CB'(sy), CB'(ex), CB'(ey), made);
	endtask

	task automatic start_line(input int sx, input int sy, input int ex, input int ey);
		bit made;
		send_command(CMD_START, sx, sy, ex, ey, made);
	endtask

	task automatic step_line(input int n);
		bit made;
		repeat (n)
			send_command(CMD_STEP, $urandom, $urandom, $urandom, $urandom, made);
	endtask

	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_frame(input logic [FRAME_BITS-1:0] w, input logic [FRAME_BITS-1:0] h);
		cfg_we <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		fb_width = w;
		fb_height = h;
	endtask

	function automatic int clamp_coord(input int v);
		if (v < -(1 << (CB - 1)))
			return -(1 << (CB - 1));
		if (v > (1 << (CB - 1)) - 1)
			return (1 << (CB - 1)) - 1;
		return v;
	endfunction

	function automatic int pick_coord(input int limit);
		int lim;
		lim = limit > (1 << (CB - 1)) ? (1 << (CB - 1)) : limit;
		case ($urandom_range(0, 5))
			0: return int'($urandom_range(0, 4)) - 2;
			1: return clamp_coord(lim - 3 + int'($urandom_range(0, 4)));
			2, 3: return lim > 0 ? int'($urandom_range(0, lim - 1)) : 0;
			4: return int'($signed(CB'($urandom)));
			default: return $urandom_range(0, 1) ? (1 << (CB - 1)) - 1 : -(1 << (CB - 1));
		endcase
	endfunction

	task automatic random_line(inout int counted);
		int x0;
		int y0;
		int x1;
		int y1;
		int len;
		int n;
		int r;
		int mag;
		bit made;
		x0 = pick_coord(int'(fb_width));
		y0 = pick_coord(int'(fb_height));
		r = $urandom_range(0, 9);
		if (r < 6) begin
			x1 = clamp_coord(x0 + int'($urandom_range(0, 24)) - 12);
			y1 = clamp_coord(y0 + int'($urandom_range(0, 24)) - 12);
		end else if (r < 8) begin
			x1 = int'($signed(CB'($urandom)));
			y1 = int'($signed(CB'($urandom)));
		end else begin
			mag = $urandom_range(1, 12);
			x1 = clamp_coord($urandom_range(0, 1) ? x0 + mag : x0 - mag);
			y1 = clamp_coord($urandom_range(0, 1) ? y0 + mag : y0 - mag);
		end
		len = (x1 > x0 ? x1 - x0 : x0 - x1);
		if ((y1 > y0 ? y1 - y0 : y0 - y1) > len)
			len = y1 > y0 ? y1 - y0 : y0 - y1;
		send_command(CMD_START, x0, y0, x1, y1, made);
		counted++;
		r = $urandom_range(0, 9);
		if (len > 40)
			n = $urandom_range(0, 40);
		else if (r < 7)
			n = len + $urandom_range(0, 1);
		else if (r < 9)
			n = $urandom_range(0, len);
		else
			n = 0;
		repeat (n) begin
			send_command(CMD_STEP, $urandom, $urandom, $urandom, $urandom, made);
			if (made)
				counted++;
		end
	endtask

	task automatic test_idle_commands();
		step_line(1);
		start_line(5, 5, 5, 5);
		step_line(1);
	endtask

	task automatic test_directed_lines();
		start_line(-2048, -2048, 2047, 2047);
		step_line(2);
		start_line(10, 10, 12, 15);
		step_line(6);
		start_line(639, 479, 641, 479);
		step_line(2);
		start_line(0, 0, 0, -2);
		step_line(1);
		start_line(2047, -2048, 2040, -2046);
		step_line(2);
	endtask

	task automatic test_resize_mid_line();
		start_line(630, 470, 650, 470);
		step_line(3);
		wait_drained();
		set_frame(13'd632, 13'd480);
		step_line(2);
	endtask

	task automatic test_random_lines();
		int phase_w[7] = '{640, 1, 4096, 0, 8191, 0, 37};
		int phase_h[7] = '{480, 1, 4096, 8191, 8191, 0, 4096};
		int counted;
		for (int p = 0; p < 7; p++) begin
			wait_drained();
			if (p == 5)
				set_frame(FRAME_BITS'($urandom_range(1, 4096)),
					FRAME_BITS'($urandom_range(1, 4096)));
			else
				set_frame(FRAME_BITS'(phase_w[p]), FRAME_BITS'(phase_h[p]));
			no_idle = (p == 2);
			counted = 0;
			while (counted < ITEMS_PER_PHASE)
				random_line(counted);
		end
		no_idle = 0;
	endtask

	always @(posedge clk)
		pix_ch.ready <= no_idle || ($urandom_range(0, 99) >= 17);

	always @(posedge clk) begin : check_pixels
		pixel_t want;
		if (arst_n && pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) begin
			if (pending_pixels.size() == 0) begin
				report_error($sformatf("pixel (%0d,%0d) with none pending",
					pix_ch.pixel_x, pix_ch.pixel_y));
			end else begin
				want = pending_pixels.pop_front();
				checked_pixels++;
				compare_field("pixel_x", 32'(pix_ch.pixel_x), 32'(want.x));
				compare_field("pixel_y", 32'(pix_ch.pixel_y), 32'(want.y));
				compare_field("on_screen", 32'(pix_ch.on_screen), 32'(want.on));
				compare_field("pixel_index", 32'(pix_ch.pixel_index), 32'(want.idx));
				compare_field("last_pixel", 32'(pix_ch.last_pixel), 32'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
			(pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: watchdog expired with %0d pixels pending", pending_pixels.size());
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_wdata <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.command <= CMD_START;
		cmd_ch.start_x <= '0;
		cmd_ch.start_y <= '0;
		cmd_ch.end_x <= '0;
		cmd_ch.end_y <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_idle_commands();
		test_directed_lines();
		test_resize_mid_line();
		test_random_lines();
		wait_drained();
		$display("tb: %0d commands sent, %0d pixels checked, %0d mismatches",
			sent_cmds, checked_pixels, errors);
		$display("tb: covered all octants and axis cases over eight frame settings");
		if (errors == 0 && pending_pixels.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
